>>> design/sao_pkg.sv
// Shared constants, payload types and helpers for the swerve angle optimizer.
`default_nettype none

package sao_pkg;

  // Q16.16 angle constants
  localparam int unsigned PI_Q      = 205887;
  localparam int unsigned TWO_PI_Q  = 411774;
  localparam int unsigned HALF_PI_Q = 102944;

  // CORDIC start value (gain compensation), Q2.30
  localparam int unsigned GAIN_Q30  = 652032874;
  localparam int unsigned ROUND_HALF = 16384;

  localparam int unsigned ATAN_ENTRIES = 24;

  // Widths
  localparam int unsigned UW    = 34;  // biased angle error
  localparam int unsigned RW    = 19;  // residue in [0, 2pi)
  localparam int unsigned AW    = 21;  // signed residue work width
  localparam int unsigned DW    = 32;  // CORDIC datapath
  localparam int unsigned SAT_W = 34;  // saturation helper input

  // Error is biased by 10431 * 2pi so it is never negative; 15 reduce cells
  // (2pi << 14 down to 2pi << 0) bring it below 2pi.
  localparam logic [UW-1:0] MOD_OFFSET = 34'd4295214594;
  localparam int unsigned   MOD_CELLS  = 15;

  // Truncated arctangents, Q2.30
  localparam logic signed [DW-1:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    32'sh3243F6A8, 32'sh1DAC6705, 32'sh0FADBAFC, 32'sh07F56EA6,
    32'sh03FEAB76, 32'sh01FFD55B, 32'sh00FFFAAA, 32'sh007FFF55,
    32'sh003FFFEA, 32'sh001FFFFD, 32'sh000FFFFF, 32'sh0007FFFF,
    32'sh0003FFFF, 32'sh0001FFFF, 32'sh0000FFFF, 32'sh00007FFF,
    32'sh00003FFF, 32'sh00001FFF, 32'sh00000FFF, 32'sh000007FF,
    32'sh000003FF, 32'sh000001FF, 32'sh000000FF, 32'sh0000007F
  };

  // Request fields that ride along the whole pipe
  typedef struct packed {
    logic signed [31:0] tgt;
    logic signed [15:0] spd;
    logic signed [31:0] cur;
    logic               ok;
    logic               e_neg;   // target - current < 0
    logic               ep_neg;  // target + pi - current < 0
  } sao_side_t;

  typedef struct packed {
    sao_side_t       side;
    logic [UW-1:0]   u;
  } sao_mod_t;

  typedef struct packed {
    sao_side_t              side;
    logic [RW-1:0]          res;   // error mod 2pi
    logic                   neg;   // cosine folded by a half turn
    logic signed [DW-1:0]   x;
    logic signed [DW-1:0]   y;
    logic signed [DW-1:0]   z;
  } sao_rot_t;

  // Clamp to signed 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [SAT_W-1:0] v);
    logic [SAT_W-16:0] top;
    top = v[SAT_W-1:15];
    if (top == '0 || top == '1) begin
      return v[15:0];
    end
    return v[SAT_W-1] ? 16'sh8000 : 16'sh7fff;
  endfunction

endpackage

`default_nettype wire

>>> design/sao_mod_cell.sv
// One restoring reduce cell: subtracts 2pi << SHIFT when the error allows.
`default_nettype none

module sao_mod_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  sao_pkg::sao_mod_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output sao_pkg::sao_mod_t data_o
);
  import sao_pkg::*;

  localparam logic [UW-1:0] STEP = UW'(TWO_PI_Q) << SHIFT;

  logic     v_q;
  sao_mod_t d_d, d_q;

  assign ready_o = ~v_q | ready_i;
  assign valid_o = v_q;
  assign data_o  = d_q;

  always_comb begin
    d_d = data_i;
    if (data_i.u >= STEP) begin
      d_d.u = data_i.u - STEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      d_q <= d_d;
    end
  end

endmodule

`default_nettype wire

>>> design/sao_cordic_cell.sv
// One CORDIC rotation-mode micro-rotation with a fixed shift.
`default_nettype none

module sao_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  sao_pkg::sao_rot_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output sao_pkg::sao_rot_t data_o
);
  import sao_pkg::*;

  localparam logic signed [DW-1:0] ANGLE = ATAN_Q30[STEP];

  logic                 v_q;
  sao_rot_t             d_d, d_q;
  logic signed [DW-1:0] xs, ys;

  assign ready_o = ~v_q | ready_i;
  assign valid_o = v_q;
  assign data_o  = d_q;

  always_comb begin
    xs  = $signed(data_i.x) >>> STEP;
    ys  = $signed(data_i.y) >>> STEP;
    d_d = data_i;
    if (!data_i.z[DW-1]) begin
      d_d.x = data_i.x - ys;
      d_d.y = data_i.y + xs;
      d_d.z = data_i.z - ANGLE;
    end else begin
      d_d.x = data_i.x + ys;
      d_d.y = data_i.y - xs;
      d_d.z = data_i.z + ANGLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      d_q <= d_d;
    end
  end

endmodule

`default_nettype wire

>>> design/sao_finish.sv
// Cosine rounding, speed scaling, angle wrap and the output register.
`default_nettype none

module sao_finish (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  sao_pkg::sao_rot_t   data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic signed [31:0]  out_angle_o,
  output logic signed [15:0]  out_speed_o,
  output logic                flipped_o,
  output logic                used_position_o
);
  import sao_pkg::*;

  localparam logic [AW-1:0] PI_A  = AW'(PI_Q);
  localparam logic [AW-1:0] TPI_A = AW'(TWO_PI_Q);

  typedef struct packed {
    sao_side_t          side;
    logic [RW-1:0]      res;
    logic signed [15:0] c;
  } sao_cos_t;

  typedef struct packed {
    sao_side_t              side;
    logic signed [31:0]     prod;
    logic signed [AW-1:0]   rd;
    logic                   flip;
  } sao_mul_t;

  // stage A: cosine to Q1.15
  logic                   a_v_q, a_rdy;
  sao_cos_t               a_d, a_q;
  logic signed [DW:0]     xw, xn;
  logic signed [DW+1:0]   xsum, xsh;

  // stage B: product and wrapped angle offset
  logic                   b_v_q, b_rdy;
  sao_mul_t               b_d, b_q;
  logic [AW-1:0]          r0, r1;
  logic signed [AW-1:0]   r2;
  logic                   dneg;

  // stage C: output register
  logic                   c_v_q, c_rdy;
  logic signed [32:0]     psum, psh;
  logic signed [31:0]     ang_d, ang_q;
  logic signed [15:0]     spd_d, spd_q;
  logic                   flip_d, flip_q, used_d, used_q;

  assign c_rdy   = ~c_v_q | ready_i;
  assign b_rdy   = ~b_v_q | c_rdy;
  assign a_rdy   = ~a_v_q | b_rdy;
  assign ready_o = a_rdy;

  always_comb begin
    xw   = {data_i.x[DW-1], data_i.x};
    xn   = data_i.neg ? -xw : xw;
    xsum = {xn[DW], xn} + (DW+2)'(ROUND_HALF);
    xsh  = xsum >>> 15;
    a_d.side = data_i.side;
    a_d.res  = data_i.res;
    a_d.c    = sat16(SAT_W'(xsh));
  end

  always_comb begin
    b_d.side = a_q.side;
    b_d.prod = 32'(a_q.side.spd) * 32'(a_q.c);
    b_d.flip = a_q.c[15];
    dneg     = b_d.flip ? a_q.side.ep_neg : a_q.side.e_neg;
    r0 = AW'(a_q.res) + (b_d.flip ? PI_A : '0);
    r1 = (r0 >= TPI_A) ? r0 - TPI_A : r0;
    r2 = (r1 > PI_A) ? $signed(r1 - TPI_A) : $signed(r1);
    // a residue of exactly pi keeps the sign of the unwrapped difference
    if (r1 == PI_A && dneg) begin
      r2 = $signed(AW'(0) - PI_A);
    end
    b_d.rd = r2;
  end

  always_comb begin
    psum  = {b_q.prod[31], b_q.prod} + 33'(ROUND_HALF);
    psh   = psum >>> 15;
    if (b_q.side.ok) begin
      ang_d  = b_q.side.cur + 32'(b_q.rd);
      spd_d  = sat16(SAT_W'(psh));
      flip_d = b_q.flip;
      used_d = 1'b1;
    end else begin
      ang_d  = b_q.side.tgt;
      spd_d  = b_q.side.spd;
      flip_d = 1'b0;
      used_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      if (a_rdy) a_v_q <= valid_i;
      if (b_rdy) b_v_q <= a_v_q;
      if (c_rdy) c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && valid_i) a_q <= a_d;
    if (b_rdy && a_v_q)   b_q <= b_d;
    if (c_rdy && b_v_q) begin
      ang_q  <= ang_d;
      spd_q  <= spd_d;
      flip_q <= flip_d;
      used_q <= used_d;
    end
  end

  assign valid_o         = c_v_q;
  assign out_angle_o     = ang_q;
  assign out_speed_o     = spd_q;
  assign flipped_o       = flip_q;
  assign used_position_o = used_q;

endmodule

`default_nettype wire

>>> design/swerve_angle_optimize.sv
// Swerve module target optimizer: cosine-scaled speed and wrapped angle.
// Pipeline: one input stage,
//   15 reduce cells for the error mod 2pi, one fold stage, one CORDIC cell
//   per step (at most 24), then cosine, multiply and output stages.
// Throughput: one beat per cycle while the output is not stalled; each stage takes a beat when it is empty
//   or its successor moves, so bubbles close up under output stalls.
// Reset clears the stage valid bits only; payload registers are not reset.
`default_nettype none

module swerve_angle_optimize #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] target_angle_i,
  input  logic signed [15:0] target_speed_i,
  input  logic signed [31:0] current_angle_i,
  input  logic               position_ok_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_angle_o,
  output logic signed [15:0] out_speed_o,
  output logic               flipped_o,
  output logic               used_position_o
);
  import sao_pkg::*;

  localparam int unsigned NSTEPS =
    (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

  localparam logic signed [AW-1:0] HALF_A = AW'(HALF_PI_Q);
  localparam logic [AW-1:0]        PI_A   = AW'(PI_Q);
  localparam logic [AW-1:0]        TPI_A  = AW'(TWO_PI_Q);
  localparam logic signed [DW-1:0] Z_LIM  = DW'(HALF_PI_Q) <<< 14;

  // input stage
  logic                 p_v_q, p_rdy;
  sao_mod_t             p_d, p_q;
  logic signed [UW-1:0] es, ep;

  // reduce chain
  logic [MOD_CELLS:0]   mod_v, mod_r;
  sao_mod_t             mod_d [MOD_CELLS+1];

  // fold stage
  logic                 f_v_q, f_rdy;
  sao_rot_t             f_d, f_q;
  logic [RW-1:0]        res;
  logic signed [AW-1:0] r, rf;
  logic signed [DW-1:0] zw;

  // rotation chain
  logic [NSTEPS:0]      rot_v, rot_r;
  sao_rot_t             rot_d [NSTEPS+1];

  assign p_rdy      = ~p_v_q | mod_r[0];
  assign in_ready_o = p_rdy;

  always_comb begin
    es = {{2{target_angle_i[31]}}, target_angle_i}
       - {{2{current_angle_i[31]}}, current_angle_i};
    ep = es + UW'(PI_Q);
    p_d.side.tgt    = target_angle_i;
    p_d.side.spd    = target_speed_i;
    p_d.side.cur    = current_angle_i;
    p_d.side.ok     = position_ok_i;
    p_d.side.e_neg  = es[UW-1];
    p_d.side.ep_neg = ep[UW-1];
    p_d.u           = es + MOD_OFFSET;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (p_rdy) begin
      p_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_rdy && in_valid_i) begin
      p_q <= p_d;
    end
  end

  assign mod_v[0] = p_v_q;
  assign mod_d[0] = p_q;

  for (genvar k = 0; k < MOD_CELLS; k++) begin : g_mod
    sao_mod_cell #(
      .SHIFT(MOD_CELLS - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(mod_v[k]),
      .ready_o(mod_r[k]),
      .data_i (mod_d[k]),
      .valid_o(mod_v[k+1]),
      .ready_i(mod_r[k+1]),
      .data_o (mod_d[k+1])
    );
  end

  assign mod_r[MOD_CELLS] = f_rdy;
  assign f_rdy            = ~f_v_q | rot_r[0];

  // map the residue to (-pi, pi], then fold into +-pi/2 with a sign flip
  always_comb begin
    res = mod_d[MOD_CELLS].u[RW-1:0];
    r   = (AW'(res) > PI_A) ? $signed(AW'(res) - TPI_A) : $signed(AW'(res));
    rf  = r;
    f_d.neg = 1'b0;
    if (r > HALF_A) begin
      rf      = r - $signed(PI_A);
      f_d.neg = 1'b1;
    end else if (r < -HALF_A) begin
      rf      = r + $signed(PI_A);
      f_d.neg = 1'b1;
    end
    zw       = DW'(rf);
    f_d.side = mod_d[MOD_CELLS].side;
    f_d.res  = res;
    f_d.x    = DW'(GAIN_Q30);
    f_d.y    = '0;
    f_d.z    = zw <<< 14;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (f_rdy) begin
      f_v_q <= mod_v[MOD_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_rdy && mod_v[MOD_CELLS]) begin
      f_q <= f_d;
    end
  end

  assign rot_v[0] = f_v_q;
  assign rot_d[0] = f_q;

  for (genvar i = 0; i < NSTEPS; i++) begin : g_rot
    sao_cordic_cell #(
      .STEP(i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(rot_v[i]),
      .ready_o(rot_r[i]),
      .data_i (rot_d[i]),
      .valid_o(rot_v[i+1]),
      .ready_i(rot_r[i+1]),
      .data_o (rot_d[i+1])
    );
  end

  sao_finish u_finish (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (rot_v[NSTEPS]),
    .ready_o        (rot_r[NSTEPS]),
    .data_i         (rot_d[NSTEPS]),
    .valid_o        (out_valid_o),
    .ready_i        (out_ready_i),
    .out_angle_o    (out_angle_o),
    .out_speed_o    (out_speed_o),
    .flipped_o      (flipped_o),
    .used_position_o(used_position_o)
  );

  // an empty output register lets ready reach the input through every stage
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty output register");

  a_mod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_v[MOD_CELLS] |-> (mod_d[MOD_CELLS].u < UW'(TWO_PI_Q)))
    else $error("reduce chain left a residue of 2pi or more");

  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_v_q |-> (f_q.z <= Z_LIM && f_q.z >= -Z_LIM))
    else $error("folded CORDIC angle outside +-pi/2");

  a_pass_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !used_position_o) |-> !flipped_o)
    else $error("pass-through beat marked as flipped");

endmodule

`default_nettype wire

>>> bench/swerve_check_pkg.sv
// Request and command types plus the scoreboard that predicts the swerve angle optimizer.
package swerve_check_pkg;

  localparam longint ARC_PI     = sao_pkg::PI_Q;
  localparam longint ARC_TWO_PI = sao_pkg::TWO_PI_Q;
  localparam longint ARC_HALF   = sao_pkg::HALF_PI_Q;
  localparam longint ROUND_Q15  = 16384;
  localparam int unsigned MAX_STEPS = sao_pkg::ATAN_ENTRIES;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct {
    logic signed [31:0] tgt;
    logic signed [15:0] spd;
    logic signed [31:0] cur;
    logic               ok;
  } steer_req_t;

  typedef struct {
    logic signed [31:0] angle;
    logic signed [15:0] speed;
    logic               flipped;
    logic               used;
  } wheel_cmd_t;

  class wheel_scoreboard;
    int unsigned steps;
    wheel_cmd_t  due_cmds[$];
    int unsigned errors;
    int unsigned reported;

    function new(int unsigned n);
      steps    = (n > MAX_STEPS) ? MAX_STEPS : n;
      errors   = 0;
      reported = 0;
    endfunction

    function longint clamp16(longint v);
      return (v < -32768) ? -32768 : ((v > 32767) ? 32767 : v);
    endfunction

    // Q1.15 cosine of an angle error given in Q16.16
    function longint cosine_q15(longint err);
      longint r, x, y, z, xs, ys;
      bit     neg;
      int     i;
      neg = 0;
      r = err % ARC_TWO_PI;
      if (r < 0) r += ARC_TWO_PI;
      if (r > ARC_PI) r -= ARC_TWO_PI;
      // fold into +-pi/2, the cosine changes sign
      if (r > ARC_HALF) begin
        r -= ARC_PI;
        neg = 1;
      end else if (r < -ARC_HALF) begin
        r += ARC_PI;
        neg = 1;
      end
      x = longint'(sao_pkg::GAIN_Q30);
      y = 0;
      z = r * 16384;
      for (i = 0; i < steps; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys;
          y += xs;
          z -= longint'(sao_pkg::ATAN_Q30[i]);
        end else begin
          x += ys;
          y -= xs;
          z += longint'(sao_pkg::ATAN_Q30[i]);
        end
      end
      if (neg) x = -x;
      return clamp16((x + ROUND_Q15) >>> 15);
    endfunction

    function wheel_cmd_t optimize(steer_req_t r);
      longint     tgt, cur, spd, c, d, k, ang;
      wheel_cmd_t o;
      if (!r.ok) begin
        o.angle   = r.tgt;
        o.speed   = r.spd;
        o.flipped = 1'b0;
        o.used    = 1'b0;
        return o;
      end
      tgt = longint'(r.tgt);
      cur = longint'(r.cur);
      spd = longint'(r.spd);
      c   = cosine_q15(tgt - cur);
      spd = clamp16((spd * c + ROUND_Q15) >>> 15);
      d   = tgt + ((c < 0) ? ARC_PI : 64'sd0) - cur;
      if (d > ARC_PI) begin
        k = (d - ARC_PI + ARC_TWO_PI - 1) / ARC_TWO_PI;
        d -= k * ARC_TWO_PI;
      end else if (d < -ARC_PI) begin
        k = (-ARC_PI - d + ARC_TWO_PI - 1) / ARC_TWO_PI;
        d += k * ARC_TWO_PI;
      end
      ang       = cur + d;
      o.angle   = ang[31:0];
      o.speed   = spd[15:0];
      o.flipped = (c < 0);
      o.used    = 1'b1;
      return o;
    endfunction

    function void note_request(steer_req_t r);
      due_cmds.push_back(optimize(r));
    endfunction

    function void check_result(wheel_cmd_t got);
      wheel_cmd_t exp_cmd;
      if (due_cmds.size() == 0) begin
        errors++;
        if (reported < REPORT_MAX) begin
          reported++;
          $display("%0t: result beat with nothing outstanding: angle %h speed %h",
                   $time, got.angle, got.speed);
        end
        return;
      end
      exp_cmd = due_cmds.pop_front();
      if (got.angle !== exp_cmd.angle || got.speed !== exp_cmd.speed ||
          got.flipped !== exp_cmd.flipped || got.used !== exp_cmd.used) begin
        errors++;
        if (reported < REPORT_MAX) begin
          reported++;
          $display("%0t: mismatch exp/got angle %h/%h speed %h/%h flip %b/%b used %b/%b",
                   $time, exp_cmd.angle, got.angle, exp_cmd.speed, got.speed,
                   exp_cmd.flipped, got.flipped, exp_cmd.used, got.used);
        end
      end
    endfunction

    function int unsigned outstanding();
      return due_cmds.size();
    endfunction
  endclass

endpackage

>>> bench/tb_top.sv
// Top-level testbench for the swerve angle optimizer: stimulus, stalls and result checking.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import swerve_check_pkg::*;

  localparam int unsigned STEPS       = 16;
  localparam int unsigned LATENCY     = STEPS + 20;
  localparam int unsigned RANDOM_REQS = 700;
  localparam int unsigned CALM_FROM   = 600;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          PI_I        = sao_pkg::PI_Q;
  localparam int          TWO_PI_I    = sao_pkg::TWO_PI_Q;
  localparam int          HALF_I      = sao_pkg::HALF_PI_Q;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [31:0] target_angle_i;
  logic signed [15:0] target_speed_i;
  logic signed [31:0] current_angle_i;
  logic               position_ok_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] out_angle_o;
  logic signed [15:0] out_speed_o;
  logic               flipped_o;
  logic               used_position_o;

  bit              calm = 1'b0;
  wheel_scoreboard tracker = new(STEPS);

  always #10 clk_i = ~clk_i;

  swerve_angle_optimize #(.CORDIC_STEPS(STEPS)) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .target_angle_i  (target_angle_i),
    .target_speed_i  (target_speed_i),
    .current_angle_i (current_angle_i),
    .position_ok_i   (position_ok_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_angle_o     (out_angle_o),
    .out_speed_o     (out_speed_o),
    .flipped_o       (flipped_o),
    .used_position_o (used_position_o)
  );

  // Holds valid until the beat is taken; valid is left high for the caller.
  task automatic drive_request(input steer_req_t r);
    in_valid_i      <= 1'b1;
    target_angle_i  <= r.tgt;
    target_speed_i  <= r.spd;
    current_angle_i <= r.cur;
    position_ok_i   <= r.ok;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_request(r);
  endtask

  task automatic send_fields(input logic signed [31:0] tgt, input logic signed [15:0] spd,
                             input logic signed [31:0] cur, input logic ok);
    steer_req_t r;
    r.tgt = tgt;
    r.spd = spd;
    r.cur = cur;
    r.ok  = ok;
    drive_request(r);
  endtask

  function automatic steer_req_t pick_request();
    steer_req_t r;
    int         k;
    int         off;
    k     = $urandom_range(0, 99);
    r.spd = 16'($urandom);
    r.cur = $urandom;
    r.ok  = 1'b1;
    if ($urandom_range(0, 7) == 0) r.spd = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    if (k < 10) begin
      r.ok  = 1'b0;
      r.tgt = $urandom;
    end else if (k < 25) begin
      r.tgt = $urandom;
    end else if (k < 45) begin
      // land near the fold and wrap boundaries
      case ($urandom_range(0, 3))
        0: off = HALF_I;
        1: off = -HALF_I;
        2: off = PI_I;
        default: off = -PI_I;
      endcase
      off   = off + int'($urandom_range(0, 8)) - 4 + TWO_PI_I * (int'($urandom_range(0, 4)) - 2);
      r.tgt = r.cur + off;
    end else begin
      off   = int'($urandom_range(0, 8 * TWO_PI_I)) - 4 * TWO_PI_I;
      r.tgt = r.cur + off;
    end
    return r;
  endfunction

  // result side: ready stalls in bursts, steady once the run is calm
  initial begin
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    wheel_cmd_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.angle   = out_angle_o;
      got.speed   = out_speed_o;
      got.flipped = flipped_o;
      got.used    = used_position_o;
      tracker.check_result(got);
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int         n;
    steer_req_t r;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    target_angle_i  <= '0;
    target_speed_i  <= '0;
    current_angle_i <= '0;
    position_ok_i   <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pass-through with extreme fields
    send_fields(32'sh7fffffff, 16'sh7fff, 32'sh80000000, 1'b0);
    send_fields(32'sh80000000, 16'sh8000, 32'sh7fffffff, 1'b0);
    // zero error, full-scale speed both ways
    send_fields(32'sh0, 16'sh7fff, 32'sh0, 1'b1);
    send_fields(32'sh0, 16'sh8000, 32'sh0, 1'b1);
    send_fields(32'sh12345, 16'sh0, 32'sh12345, 1'b1);
    // error of exactly plus and minus a half turn
    send_fields(PI_I, 16'sh0100, 32'sh0, 1'b1);
    send_fields(-PI_I, 16'sh0100, 32'sh0, 1'b1);
    send_fields(32'sh0, 16'sh0100, PI_I, 1'b1);
    // around the quarter turn, on both sides
    send_fields(HALF_I - 1, 16'sh7fff, 32'sh0, 1'b1);
    send_fields(HALF_I, 16'sh7fff, 32'sh0, 1'b1);
    send_fields(HALF_I + 1, 16'sh7fff, 32'sh0, 1'b1);
    send_fields(HALF_I + 2, 16'sh8000, 32'sh0, 1'b1);
    send_fields(-HALF_I, 16'sh7fff, 32'sh0, 1'b1);
    send_fields(-HALF_I - 1, 16'sh8000, 32'sh0, 1'b1);
    send_fields(-HALF_I - 2, 16'sh7fff, 32'sh0, 1'b1);
    // full-range errors and angle wrap past the 32-bit limits
    send_fields(32'sh7fffffff, 16'sh7fff, 32'sh80000000, 1'b1);
    send_fields(32'sh80000000, 16'sh8000, 32'sh7fffffff, 1'b1);
    send_fields(32'sh80000010, 16'sh0200, 32'sh7fff0000, 1'b1);
    send_fields(32'sh7fffff00, 16'sh0200, 32'sh80000100, 1'b1);
    send_fields(32'sh7fffffff, 16'sh0200, 32'sh7ffe0000, 1'b1);
    // multi-turn errors
    send_fields(7 * PI_I + 1000, 16'sh0300, 32'sh0, 1'b1);
    send_fields(-9 * PI_I - 1000, 16'shfd00, 32'sh0, 1'b1);
    send_fields(32'shffffffff, 16'shffff, 32'shffffffff, 1'b1);

    for (n = 0; n < RANDOM_REQS; n++) begin
      if (n == CALM_FROM) calm = 1'b1;
      if (!calm && !(n >= 300 && n < 380) && $urandom_range(0, 3) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      r = pick_request();
      drive_request(r);
    end
    in_valid_i <= 1'b0;

    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
